// ===== rtl/kdt_pkg.sv =====
// ============================================================================
// kdt_pkg - shared types and codes for the keyed device table
// Request kind codes and the command bundle from controller to datapath.
// ============================================================================
package kdt_pkg;

    localparam int KIND_W  = 2;
    localparam int KEY_W   = 64;
    localparam int SLOT_W  = 4;
    localparam int TOTAL_W = 5;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TOGGLE = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic load;     // request accepted: capture fields and match vector
        logic commit;   // apply the request to the table, load result
    } kdt_cmd_t;

endpackage

// ===== rtl/kdt_ctrl.sv =====
// ============================================================================
// kdt_ctrl - request sequencer for the keyed device table
// Two-state controller: accept a request, then commit it once the result
// register is free. Owns the result valid flag.
// ============================================================================
module kdt_ctrl
    import kdt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output kdt_cmd_t cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;
    logic commit;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    // result register is free when empty or being drained this cycle
    assign commit    = (state_reg == ST_UPDATE) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;

    assign cmd.load   = accept;
    assign cmd.commit = commit;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_UPDATE))
        else $error("request accepted but controller did not move to update");

    a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("commit did not present a result");

    a_wait_holds_update: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_UPDATE) && !commit) |=> (state_reg == ST_UPDATE))
        else $error("pending request dropped without commit");
`endif

endmodule

// ===== rtl/kdt_datapath.sv =====
// ============================================================================
// kdt_datapath - key array, match logic and result register
// Parallel key compare on accept, then add, delete-with-compaction, search or
// toggle on commit.
// ============================================================================
module kdt_datapath
    import kdt_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  kdt_cmd_t           cmd,
    input  logic [KIND_W-1:0]  kind,
    input  logic [KEY_W-1:0]   name_key,
    input  logic               power_in,
    output logic               success,
    output logic [SLOT_W-1:0]  slot_index,
    output logic               power_state,
    output logic [TOTAL_W-1:0] entry_total
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [KEY_BITS-1:0] key_store_reg [ENTRIES];
    logic [ENTRIES-1:0]  power_store_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [ENTRIES-1:0]  match_reg;
    logic [ENTRIES-1:0]  match_next;
    logic [KIND_W-1:0]   kind_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                pin_reg;

    logic                success_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                power_reg;
    logic [TOTAL_W-1:0]  total_reg;

    logic                hit_any;
    logic [IDX_W-1:0]    hit_idx;
    logic                hit_power;
    logic                table_full;
    logic                add_ok;
    logic                del_ok;
    logic                tog_ok;
    logic                res_success;
    logic [SLOT_W-1:0]   res_slot;
    logic                res_power;

    // compare incoming key against every live entry
    always_comb
    begin
        for (int j = 0; j < ENTRIES; j++)
        begin
            match_next[j] = (key_store_reg[j] == name_key[KEY_BITS-1:0]) &&
                            (CNT_W'(j) < count_reg);
        end
    end

    // keys are unique, so the match vector is one-hot or empty: OR-encode
    always_comb
    begin
        hit_idx   = '0;
        hit_power = 1'b0;
        for (int j = 0; j < ENTRIES; j++)
        begin
            hit_idx   = hit_idx | (match_reg[j] ? IDX_W'(j) : '0);
            hit_power = hit_power | (match_reg[j] & power_store_reg[j]);
        end
    end

    assign hit_any    = |match_reg;
    assign table_full = (count_reg == CNT_W'(ENTRIES));
    assign add_ok     = (kind_reg == KIND_ADD) && !hit_any && !table_full;
    assign del_ok     = (kind_reg == KIND_DELETE) && hit_any;
    assign tog_ok     = (kind_reg == KIND_TOGGLE) && hit_any;

    always_comb
    begin
        if (add_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (del_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_comb
    begin
        unique case (kind_reg)
            KIND_ADD:
            begin
                res_success = add_ok;
                res_slot    = add_ok ? SLOT_W'(count_reg) : '0;
                res_power   = add_ok & pin_reg;
            end
            KIND_DELETE:
            begin
                res_success = hit_any;
                res_slot    = hit_any ? SLOT_W'(hit_idx) : '0;
                res_power   = 1'b0;
            end
            KIND_SEARCH:
            begin
                res_success = hit_any;
                res_slot    = hit_any ? SLOT_W'(hit_idx) : '0;
                res_power   = hit_power;
            end
            KIND_TOGGLE:
            begin
                res_success = hit_any;
                res_slot    = hit_any ? SLOT_W'(hit_idx) : '0;
                res_power   = hit_any & ~hit_power;
            end
            default:
            begin
                res_success = 1'b0;
                res_slot    = '0;
                res_power   = 1'b0;
            end
        endcase
    end

    // per-entry storage: append at count, shift down from the hit on delete
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_entry
        logic [KEY_BITS-1:0] key_above;
        logic                power_above;

        if (g == ENTRIES - 1)
        begin : g_top
            assign key_above   = '0;
            assign power_above = 1'b0;
        end
        else
        begin : g_mid
            assign key_above   = key_store_reg[g + 1];
            assign power_above = power_store_reg[g + 1];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.commit)
            begin
                if (add_ok && (count_reg == CNT_W'(g)))
                begin
                    key_store_reg[g] <= key_reg;
                end
                else if (del_ok && (IDX_W'(g) >= hit_idx))
                begin
                    key_store_reg[g] <= key_above;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                power_store_reg[g] <= 1'b0;
            end
            else if (cmd.commit)
            begin
                if (add_ok && (count_reg == CNT_W'(g)))
                begin
                    power_store_reg[g] <= pin_reg;
                end
                else if (del_ok && (IDX_W'(g) >= hit_idx))
                begin
                    power_store_reg[g] <= power_above;
                end
                else if (tog_ok && match_reg[g])
                begin
                    power_store_reg[g] <= ~power_store_reg[g];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            match_reg <= '0;
        end
        else
        begin
            if (cmd.commit)
            begin
                count_reg <= count_next;
            end
            if (cmd.load)
            begin
                match_reg <= match_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            key_reg  <= name_key[KEY_BITS-1:0];
            pin_reg  <= power_in;
        end
        if (cmd.commit)
        begin
            success_reg <= res_success;
            slot_reg    <= res_slot;
            power_reg   <= res_power;
            total_reg   <= TOTAL_W'(count_next);
        end
    end

    assign success     = success_reg;
    assign slot_index  = slot_reg;
    assign power_state = power_reg;
    assign entry_total = total_reg;

`ifndef SYNTHESIS
    a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_reg))
        else $error("key matched more than one live entry");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count beyond table size");

    a_full_add_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && table_full && (kind_reg == KIND_ADD))
        |=> (count_reg == $past(count_reg)))
        else $error("add into full table changed the count");
`endif

endmodule

// ===== rtl/keyed_device_table.sv =====
// ============================================================================
// keyed_device_table - ordered device table with key lookup
// Add, delete, search and power toggle on a table of keyed entries.
// ============================================================================
// A request is handled in order: on the accepting edge the key is compared
// against every live entry in parallel and the match vector is registered;
// at commit, once the result register is free, the table is updated
// (append, delete with compaction of later entries, or flag toggle) and the
// result register is loaded, after which the next request can be accepted.
// The table is a register array, so a delete closes the gap at its commit
// whatever the slot. A finished result waits in its own register while the
// next request is accepted; the commit of that request waits until the held
// result has been taken. Keys are compared on their low KEY_BITS bits only.
// No clearing pass is needed after reset: only entries below the count are
// ever compared, so key storage is not reset. slot_index carries the low four
// bits of the slot and entry_total the low five bits of the count.
// ============================================================================
module keyed_device_table
    import kdt_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [KIND_W-1:0]  kind,
    input  logic [KEY_W-1:0]   name_key,
    input  logic               power_in,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic               success,
    output logic [SLOT_W-1:0]  slot_index,
    output logic               power_state,
    output logic [TOTAL_W-1:0] entry_total
);

    kdt_cmd_t cmd;

    // sequencing and result handshake
    kdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // key array, compare and result payload
    kdt_datapath #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .kind        (kind),
        .name_key    (name_key),
        .power_in    (power_in),
        .success     (success),
        .slot_index  (slot_index),
        .power_state (power_state),
        .entry_total (entry_total)
    );

endmodule
